### src/countdown_event_timer_table_macros.svh
// ----------------------------------------------------------------------------
// Countdown event timer table assertion macros
// Shared concurrent assertion forms used by the controller and datapath.
// ----------------------------------------------------------------------------
`ifndef COUNTDOWN_EVENT_TIMER_TABLE_MACROS_SVH
`define COUNTDOWN_EVENT_TIMER_TABLE_MACROS_SVH

// Condition that must hold at every clock edge outside of reset.
`define CTT_ASSERT_ALWAYS(lbl, c, r, cond, msg) \
    lbl: assert property (@(posedge c) disable iff (!r) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define CTT_ASSERT_IMPL(lbl, c, r, ante, cons, msg) \
    lbl: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CTT_ASSERT_NEXT(lbl, c, r, ante, cons, msg) \
    lbl: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) else $error(msg);

`endif

### src/ctt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Countdown event timer table package
// Shared word types, result codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package ctt_pkg;

    localparam int SLOTS_DEF      = 16;
    localparam int TIME_WIDTH_DEF = 32;

    // Operation codes carried in the mode field.
    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // Result kinds.
    localparam logic [1:0] KIND_ADD_OK   = 2'd0;
    localparam logic [1:0] KIND_ADD_FULL = 2'd1;
    localparam logic [1:0] KIND_FIRED    = 2'd2;
    localparam logic [1:0] KIND_DONE     = 2'd3;

    typedef struct packed {
        logic        mode;
        logic [31:0] period;
        logic        repeat_req;
        logic [7:0]  event_tag;
        logic [31:0] delta;
    } req_word_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] fired_tag;
        logic       removed;
        logic       last;
    } rsp_word_t;

    typedef struct packed {
        logic       capture;
        logic       add_commit;
        logic       tick_start;
        logic       rd_issue;
        logic       entry_commit;
        logic       tick_end;
        logic       out_load;
        logic [1:0] out_kind;
    } cmd_t;

    typedef struct packed {
        logic mode;
        logic full;
        logic rd_more;
        logic fire;
        logic out_free;
    } stat_t;

endpackage

### src/ctt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ctt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/ctt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Countdown event timer table controller
// Sequences adds and table sweeps, and schedules result words.
// ----------------------------------------------------------------------------
`include "countdown_event_timer_table_macros.svh"

module ctt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  ctt_pkg::stat_t stat,
    output ctt_pkg::cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DISP  = 3'd1;
    localparam logic [2:0] ST_ADD   = 3'd2;
    localparam logic [2:0] ST_TCHK  = 3'd3;
    localparam logic [2:0] ST_TEVAL = 3'd4;
    localparam logic [2:0] ST_TDONE = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.out_kind = ctt_pkg::KIND_DONE;
        req_ready    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISP;
                end
            end
            ST_DISP:
            begin
                if (stat.mode == ctt_pkg::MODE_ADD)
                begin
                    state_next = ST_ADD;
                end
                else
                begin
                    cmd.tick_start = 1'b1;
                    state_next     = ST_TCHK;
                end
            end
            ST_ADD:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_kind   = stat.full ? ctt_pkg::KIND_ADD_FULL
                                               : ctt_pkg::KIND_ADD_OK;
                    cmd.add_commit = !stat.full;
                    state_next     = ST_IDLE;
                end
            end
            ST_TCHK:
            begin
                if (stat.rd_more)
                begin
                    cmd.rd_issue = 1'b1;
                    state_next   = ST_TEVAL;
                end
                else
                begin
                    state_next = ST_TDONE;
                end
            end
            ST_TEVAL:
            begin
                if (!stat.fire)
                begin
                    cmd.entry_commit = 1'b1;
                    state_next       = ST_TCHK;
                end
                else if (stat.out_free)
                begin
                    cmd.out_load     = 1'b1;
                    cmd.out_kind     = ctt_pkg::KIND_FIRED;
                    cmd.entry_commit = 1'b1;
                    state_next       = ST_TCHK;
                end
            end
            ST_TDONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = ctt_pkg::KIND_DONE;
                    cmd.tick_end = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `CTT_ASSERT_NEXT(a_capture_dispatch, clk, rst_n, cmd.capture, state_reg == ST_DISP, "accepted word not dispatched")
    `CTT_ASSERT_IMPL(a_load_state, clk, rst_n, cmd.out_load, (state_reg == ST_ADD) || (state_reg == ST_TEVAL) || (state_reg == ST_TDONE), "result loaded from wrong state")
    `CTT_ASSERT_NEXT(a_read_eval, clk, rst_n, cmd.rd_issue, state_reg == ST_TEVAL, "table read not followed by evaluation")

endmodule

### src/ctt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Countdown event timer table datapath
// Timer table storage, sweep pointers, countdown arithmetic and result register.
// ----------------------------------------------------------------------------
`include "countdown_event_timer_table_macros.svh"

module ctt_dp #(
    parameter int SLOTS      = ctt_pkg::SLOTS_DEF,
    parameter int TIME_WIDTH = ctt_pkg::TIME_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctt_pkg::req_word_t   req,
    input  ctt_pkg::cmd_t        cmd,
    output ctt_pkg::stat_t       stat,
    input  logic                 rsp_ready,
    output logic                 rsp_valid,
    output ctt_pkg::rsp_word_t   rsp
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int ENT_W = 2 * TIME_WIDTH + 9;

    ctt_pkg::req_word_t in_reg;
    ctt_pkg::rsp_word_t out_reg;
    ctt_pkg::rsp_word_t out_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W-1:0]   rd_reg;
    logic [CNT_W-1:0]   rd_next;
    logic [CNT_W-1:0]   wr_reg;
    logic [CNT_W-1:0]   wr_next;

    logic [TIME_WIDTH-1:0] period_t;
    logic [TIME_WIDTH-1:0] delta_t;
    logic [TIME_WIDTH-1:0] ent_rem;
    logic [TIME_WIDTH-1:0] ent_per;
    logic [TIME_WIDTH-1:0] rem_new;
    logic                  ent_flag;
    logic [7:0]            ent_tag;
    logic                  fire;
    logic                  keep;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [ENT_W-1:0]      ram_wdata;
    logic [ENT_W-1:0]      ram_rdata;

    // Input times clamp to the largest value the table can hold.
    assign period_t = ((in_reg.period >> TIME_WIDTH) != 32'd0) ? {TIME_WIDTH{1'b1}}
                                                               : TIME_WIDTH'(in_reg.period);
    assign delta_t  = ((in_reg.delta >> TIME_WIDTH) != 32'd0) ? {TIME_WIDTH{1'b1}}
                                                              : TIME_WIDTH'(in_reg.delta);

    assign ent_rem  = ram_rdata[ENT_W-1 -: TIME_WIDTH];
    assign ent_per  = ram_rdata[TIME_WIDTH+8 -: TIME_WIDTH];
    assign ent_flag = ram_rdata[8];
    assign ent_tag  = ram_rdata[7:0];

    assign fire    = delta_t > ent_rem;
    assign rem_new = fire ? ent_per : (ent_rem - delta_t);
    assign keep    = !fire || ent_flag;

    // Survivors are written back at the compaction pointer, never ahead of the read pointer.
    assign ram_we    = cmd.add_commit || (cmd.entry_commit && keep);
    assign ram_waddr = cmd.add_commit ? count_reg[IDX_W-1:0] : wr_reg[IDX_W-1:0];
    assign ram_wdata = cmd.add_commit
                       ? {period_t, period_t, in_reg.repeat_req, in_reg.event_tag}
                       : {rem_new, ent_per, ent_flag, ent_tag};

    ctt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_issue),
        .raddr (rd_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        stat.mode     = in_reg.mode;
        stat.full     = count_reg >= CNT_W'(SLOTS);
        stat.rd_more  = rd_reg < count_reg;
        stat.fire     = fire;
        stat.out_free = !out_valid_reg || rsp_ready;
    end

    always_comb
    begin
        out_next.kind      = cmd.out_kind;
        out_next.fired_tag = 8'd0;
        out_next.removed   = 1'b0;
        out_next.last      = 1'b1;
        case (cmd.out_kind)
            ctt_pkg::KIND_FIRED:
            begin
                out_next.fired_tag = ent_tag;
                out_next.removed   = !ent_flag;
                out_next.last      = 1'b0;
            end
            default:
            begin
                out_next.last = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        rd_next        = rd_reg;
        wr_next        = wr_reg;
        out_valid_next = out_valid_reg;
        if (cmd.add_commit)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.tick_end)
        begin
            count_next = wr_reg;
        end
        if (cmd.tick_start)
        begin
            rd_next = '0;
            wr_next = '0;
        end
        else if (cmd.entry_commit)
        begin
            rd_next = rd_reg + CNT_W'(1);
            wr_next = wr_reg + CNT_W'(keep);
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_reg        <= '0;
            wr_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rd_reg        <= rd_next;
            wr_reg        <= wr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_reg <= req;
        end
        if (cmd.out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    `CTT_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_W'(SLOTS), "timer count above table size")
    `CTT_ASSERT_ALWAYS(a_wr_behind_rd, clk, rst_n, wr_reg <= rd_reg, "compaction pointer passed read pointer")
    `CTT_ASSERT_IMPL(a_load_free, clk, rst_n, cmd.out_load, !out_valid_reg || rsp_ready, "result register overwritten")

endmodule

### src/countdown_event_timer_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Countdown event timer table
// Ordered table of one-shot and periodic countdown timers driven by ticks.
// ----------------------------------------------------------------------------
// Usage: request words arrive on req/req_valid/req_ready and result words
// leave on rsp/rsp_valid/rsp_ready. An add word (mode 0) appends a timer and
// answers with one word, accepted or rejected when the table is full. A tick
// word (mode 1) subtracts delta from every timer in insertion order; each
// timer that runs past zero reports a fired word, reloads its period, and is
// removed if one-shot. The tick ends with a done word marked last.
// Timing: the block works on one request at a time. An add passes through
// capture, dispatch and the add state to its result. A tick reads and writes
// back each stored timer in turn, through the single table memory; a new
// request is taken in the cycle after the last result is loaded.
// Reset empties the table (the timer count clears; the table memory keeps no
// reset value). A stalled receiver holds the result register, and the sweep
// waits in place on the next fired or done word until the register frees.
// ----------------------------------------------------------------------------
module countdown_event_timer_table #(
    parameter int SLOTS      = ctt_pkg::SLOTS_DEF,
    parameter int TIME_WIDTH = ctt_pkg::TIME_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  ctt_pkg::req_word_t req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output ctt_pkg::rsp_word_t rsp
);

    // Command and status between the sequencer and the table datapath.
    ctt_pkg::cmd_t  cmd;
    ctt_pkg::stat_t stat;

    // The controller owns the request handshake and the sweep order.
    ctt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath holds the timer memory, pointers and the result register.
    ctt_dp #(
        .SLOTS      (SLOTS),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_ready (rsp_ready),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule
